/* rtl/core/rhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared widths, hue constants, the word carried through the divider
// pipeline, and the long-division step functions.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Field widths.
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;

    // Quotient bits of the two divisions; one divider stage per hue bit.
    localparam int HUE_Q_W   = 12;
    localparam int SAT_Q_W   = 8;
    localparam int HUE_ACC_W = CH_W + HUE_Q_W;
    localparam int SAT_ACC_W = CH_W + SAT_Q_W;

    // Hue constants in 1/64 degree units.
    localparam logic [HUE_W-1:0] HUE_SIXTH = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

    // Saturation full scale.
    localparam logic [CH_W-1:0] SAT_SCALE = 8'd255;

    // Word that travels down the divider pipeline.
    typedef struct packed {
        logic [HUE_ACC_W-1:0] hue_acc;   // remainder and quotient of the hue division
        logic [SAT_ACC_W-1:0] sat_acc;   // remainder and quotient of the saturation division
        logic [CH_W-1:0]      delta;     // hue divisor
        logic [CH_W-1:0]      bright;    // saturation divisor and value output
        logic [HUE_W-1:0]     hue_base;  // sector offset of the hue
        logic                 neg;       // hue difference is negative
        logic                 grey;      // max equals min
    } t_div_stage;

    // One restoring long-division step on the hue accumulator.
    function automatic logic [HUE_ACC_W-1:0] hue_step(
        input logic [HUE_ACC_W-1:0] acc,
        input logic [CH_W-1:0]      den
    );
        logic [CH_W:0] cand;
        logic [CH_W:0] diff;
        logic          qbit;
        cand = acc[HUE_ACC_W-1 -: CH_W+1];
        qbit = (cand >= {1'b0, den});
        diff = qbit ? (cand - {1'b0, den}) : cand;
        return {diff[CH_W-1:0], acc[HUE_Q_W-2:0], qbit};
    endfunction

    // One restoring long-division step on the saturation accumulator.
    function automatic logic [SAT_ACC_W-1:0] sat_step(
        input logic [SAT_ACC_W-1:0] acc,
        input logic [CH_W-1:0]      den
    );
        logic [CH_W:0] cand;
        logic [CH_W:0] diff;
        logic          qbit;
        cand = acc[SAT_ACC_W-1 -: CH_W+1];
        qbit = (cand >= {1'b0, den});
        diff = qbit ? (cand - {1'b0, den}) : cand;
        return {diff[CH_W-1:0], acc[SAT_Q_W-2:0], qbit};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/rhc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max, min and the hue sector of a pixel and forms the two dividends.
// ----------------------------------------------------------------------------
module rhc_front
    import rhc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    output logic                 o_valid,
    output t_div_stage           o_data,
    input  wire logic            i_stall
);

    logic       r_valid;
    t_div_stage r_data;
    t_div_stage n_data;
    logic       w_en;

    logic            w_red_max;
    logic            w_green_max;
    logic [CH_W-1:0] w_max;
    logic [CH_W-1:0] w_min;
    logic [CH_W-1:0] w_a;
    logic [CH_W-1:0] w_b;
    logic [CH_W-1:0] w_delta;
    logic [CH_W-1:0] w_mag;
    logic            w_neg;

    // Max, min and sector; red wins ties, then green.
    always_comb begin
        w_red_max   = (i_red >= i_green) && (i_red >= i_blue);
        w_green_max = !w_red_max && (i_green >= i_blue);
        if (w_red_max) begin
            w_max = i_red;
            w_a   = i_green;
            w_b   = i_blue;
        end else if (w_green_max) begin
            w_max = i_green;
            w_a   = i_blue;
            w_b   = i_red;
        end else begin
            w_max = i_blue;
            w_a   = i_red;
            w_b   = i_green;
        end
        w_min = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blue < w_min) w_min = i_blue;
        w_delta = w_max - w_min;
        w_neg   = (w_a < w_b);
        w_mag   = w_neg ? (w_b - w_a) : (w_a - w_b);
    end

    // Dividends and sector offset for the divider pipeline.
    always_comb begin
        n_data.hue_acc = HUE_ACC_W'(w_mag) * HUE_ACC_W'(HUE_SIXTH);
        n_data.sat_acc = SAT_ACC_W'(w_delta) * SAT_ACC_W'(SAT_SCALE);
        n_data.delta   = w_delta;
        n_data.bright  = w_max;
        n_data.neg     = w_neg;
        n_data.grey    = (w_delta == '0);
        if (w_red_max) begin
            n_data.hue_base = w_neg ? HUE_FULL : '0;
        end else if (w_green_max) begin
            n_data.hue_base = HUE_GREEN;
        end else begin
            n_data.hue_base = HUE_BLUE;
        end
    end

    // The stage loads when it is empty or its word moves on.
    assign w_en    = !r_valid || !i_stall;
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

/* rtl/core/rhc_div_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV divider pipeline
// Restoring division, one quotient bit per register stage, for the hue and
// saturation quotients in lockstep. Bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module rhc_div_pipe
    import rhc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_div_stage i_data,
    output logic            o_valid,
    output t_div_stage      o_data,
    input  wire logic       i_stall
);

    t_div_stage             r_stage [HUE_Q_W];
    t_div_stage             n_stage [HUE_Q_W];
    logic [HUE_Q_W-1:0]     r_vld;
    logic [HUE_Q_W:0]       w_stall;

    // Stall chain: a full stage holds when the one after it holds.
    assign w_stall[HUE_Q_W] = i_stall;

    for (genvar k = 0; k < HUE_Q_W; k++) begin : g_stage
        logic       w_in_vld;
        t_div_stage w_in;

        if (k == 0) begin : g_first
            assign w_in_vld = i_valid;
            assign w_in     = i_data;
        end else begin : g_next
            assign w_in_vld = r_vld[k-1];
            assign w_in     = r_stage[k-1];
        end

        assign w_stall[k] = r_vld[k] && w_stall[k+1];

        // One quotient bit; saturation needs only the first few stages.
        always_comb begin
            n_stage[k]         = w_in;
            n_stage[k].hue_acc = hue_step(w_in.hue_acc, w_in.delta);
            if (k < SAT_Q_W) begin
                n_stage[k].sat_acc = sat_step(w_in.sat_acc, w_in.bright);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (!w_stall[k]) begin
                r_vld[k] <= w_in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_stall[k] && w_in_vld) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_stall = w_stall[0];
    assign o_valid = r_vld[HUE_Q_W-1];
    assign o_data  = r_stage[HUE_Q_W-1];

endmodule
`default_nettype wire

/* rtl/core/rgb_to_hsv_converter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts 8-bit RGB pixels to hue (1/64 degree), saturation and value.
// ----------------------------------------------------------------------------
// The converter takes one pixel word per clock while o_stall is low and returns
// one HSV word per pixel, in order. A pixel passes through the front stage that
// finds max, min and the sector, then the divider pipeline that produces one
// bit of the hue quotient per stage (the saturation quotient rides along in the
// same stages), then the output register that adds the sector offset. A stall
// on the output holds only the stages that are full, so empty slots keep
// filling while a result waits. Grey pixels report hue and saturation of zero.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [CH_W-1:0]  i_red,
    input  wire logic [CH_W-1:0]  i_green,
    input  wire logic [CH_W-1:0]  i_blue,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [HUE_W-1:0]      o_hue,
    output logic [CH_W-1:0]       o_saturation,
    output logic [CH_W-1:0]       o_brightness
);

    logic       w_front_vld;
    logic       w_front_stall;
    t_div_stage w_front_data;
    logic       w_div_vld;
    logic       w_div_stall;
    t_div_stage w_div_data;

    logic                 r_out_valid;
    logic [HUE_W-1:0]     r_hue;
    logic [CH_W-1:0]      r_sat;
    logic [CH_W-1:0]      r_bright;
    logic [HUE_W-1:0]     n_hue;
    logic [CH_W-1:0]      n_sat;
    logic                 w_out_en;
    logic [HUE_Q_W-1:0]   w_q;
    logic [CH_W-1:0]      w_rem;
    logic [HUE_W-1:0]     w_mag;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_front_vld),
        .o_data  (w_front_data),
        .i_stall (w_front_stall)
    );

    rhc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_vld),
        .o_stall (w_front_stall),
        .i_data  (w_front_data),
        .o_valid (w_div_vld),
        .o_data  (w_div_data),
        .i_stall (w_div_stall)
    );

    // Hue: floor of a negative quotient rounds the magnitude up.
    always_comb begin
        w_q   = w_div_data.hue_acc[HUE_Q_W-1:0];
        w_rem = w_div_data.hue_acc[HUE_ACC_W-1 -: CH_W];
        w_mag = HUE_W'(w_q) + HUE_W'(w_div_data.neg && (w_rem != '0));
        if (w_div_data.grey) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = w_div_data.neg ? (w_div_data.hue_base - w_mag)
                                   : (w_div_data.hue_base + w_mag);
            n_sat = w_div_data.sat_acc[SAT_Q_W-1:0];
        end
    end

    // Output register.
    assign w_out_en    = !r_out_valid || !i_stall;
    assign w_div_stall = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && w_div_vld) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= w_div_data.bright;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule
`default_nettype wire

/* rtl/core/rhc_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_chk
    import rhc_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic [HUE_W-1:0] o_hue,
    input wire logic [CH_W-1:0]  o_saturation,
    input wire logic [CH_W-1:0]  o_brightness
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue)
            && $stable(o_saturation) && $stable(o_brightness))
        else $error("stalled result word changed");

    // Hue stays below a full turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HUE_FULL))
        else $error("hue out of range");

    // Zero saturation only for grey pixels, which carry zero hue.
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_saturation == '0) |-> (o_hue == '0))
        else $error("unsaturated word with nonzero hue");

    // A black pixel carries zero saturation.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_brightness == '0) |-> (o_saturation == '0))
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_converter rhc_chk u_rhc_chk (.*);
`default_nettype wire
